### design/glct_pkg.sv
// shared constants, codes and types of the grid line cell traversal block
package glct_pkg;

    // grid geometry
    localparam int GRID_DIM   = 32;
    localparam int CELL_W     = $clog2(GRID_DIM);
    localparam int MAX_CELLS  = 2 * GRID_DIM - 1;
    localparam int STEP_W     = $clog2(MAX_CELLS + 1);

    // field widths
    localparam int COORD_W    = 16;
    localparam int TAG_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_CELL_W = 5;

    // fixed point: 8 fractional bits per cell
    localparam int FRAC_W     = 8;
    localparam int CELL_SPAN  = 1 << FRAC_W;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAPP_W     = 2 * DIFF_W;
    localparam int GRID_W     = MAPP_W - 1 - FRAC_W;
    localparam int DELTA_W    = GRID_W + 1;
    localparam int ERR_W      = DELTA_W;
    localparam int EDGE_W     = GRID_W + 2;
    localparam int PROD_W     = 2 * ERR_W;

    localparam logic [CFG_W-1:0] SCALE_RST = CFG_W'(256);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X,
        CFG_ORIGIN_Y,
        CFG_CELL_SCALE
    } t_cfg_idx;

    typedef enum logic [1:0] {
        MAP_SX,
        MAP_SY,
        MAP_EX,
        MAP_EY
    } t_map_sel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_INIT,
        S_ERR,
        S_MUL,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic [TAG_W-1:0]          edge_tag;
    } t_seg_in;

    typedef struct packed {
        logic [OUT_CELL_W-1:0] cell_col;
        logic [OUT_CELL_W-1:0] cell_row;
        logic [TAG_W-1:0]      tag_out;
        logic                  last_cell;
        logic                  left_grid;
    } t_cell_out;

    typedef struct packed {
        logic     load_in;
        logic     map_en;
        t_map_sel map_sel;
        logic     init_en;
        logic     err_en;
        logic     mul_en;
        logic     emit_en;
    } t_dp_cmd;

    typedef struct packed {
        logic stop;
    } t_dp_sts;

endpackage

### design/glct_ctrl.sv
// sequencer of the traversal: set-up, per-cell multiply and emit, output slot
module glct_ctrl import glct_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state   r_state;
    t_state   n_state;
    t_map_sel r_map_sel;
    t_map_sel n_map_sel;
    logic     r_out_valid;
    logic     n_out_valid;
    t_dp_cmd  cmd;
    logic     out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map_sel   <= MAP_SX;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map_sel   <= n_map_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_map_sel   = r_map_sel;
        cmd         = '0;
        cmd.map_sel = r_map_sel;
        // output slot is free when empty or being taken this cycle
        out_free    = !r_out_valid || !i_out_stall;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load_in = 1'b1;
                    n_map_sel   = MAP_SX;
                    n_state     = S_MAP;
                end
            end
            S_MAP: begin
                cmd.map_en = 1'b1;
                if (r_map_sel == MAP_EY) begin
                    n_state = S_INIT;
                end else begin
                    n_map_sel = t_map_sel'(r_map_sel + 1'b1);
                end
            end
            S_INIT: begin
                cmd.init_en = 1'b1;
                n_state     = S_ERR;
            end
            S_ERR: begin
                cmd.err_en = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit_en = 1'b1;
                    n_state     = i_sts.stop ? S_IDLE : S_MUL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = cmd.emit_en || (r_out_valid && i_out_stall);
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### design/glct_dpath.sv
// datapath: registers, grid mapping multiplier, crossing products and step logic
module glct_dpath import glct_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_seg_in              i_in_data,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    output t_cell_out            o_out_data
);

    logic signed [COORD_W-1:0] r_org_x;
    logic signed [COORD_W-1:0] r_org_y;
    logic [CFG_W-1:0]          r_scale;

    t_seg_in                   r_seg;
    logic signed [GRID_W-1:0]  r_gsx;
    logic signed [GRID_W-1:0]  r_gsy;
    logic signed [GRID_W-1:0]  r_gex;
    logic signed [GRID_W-1:0]  r_gey;
    logic signed [DELTA_W-1:0] r_dx;
    logic signed [DELTA_W-1:0] r_dy;
    logic [ERR_W-1:0]          r_adx;
    logic [ERR_W-1:0]          r_ady;
    logic [CELL_W-1:0]         r_col;
    logic [CELL_W-1:0]         r_row;
    logic [ERR_W-1:0]          r_err_x;
    logic [ERR_W-1:0]          r_err_y;
    logic [PROD_W-1:0]         r_prod_x;
    logic [PROD_W-1:0]         r_prod_y;
    logic [STEP_W-1:0]         r_steps;
    t_cell_out                 r_out;

    logic signed [COORD_W-1:0] map_pt;
    logic signed [COORD_W-1:0] map_org;
    logic signed [DIFF_W-1:0]  map_diff;
    logic signed [MAPP_W-1:0]  map_prod;
    logic signed [GRID_W-1:0]  map_grid;

    logic dx_nz;
    logic dy_nz;
    logic pick_x;
    logic pick_y;
    logic at_edge_x;
    logic at_edge_y;
    logic stop;
    logic border;

    function automatic logic [CELL_W-1:0] clamp_cell(input logic signed [GRID_W-1:0] g);
        logic signed [GRID_W-FRAC_W-1:0] c;
        c = g[GRID_W-1:FRAC_W];
        if (c < 0) begin
            return '0;
        end else if (c > $signed((GRID_W-FRAC_W)'(GRID_DIM - 1))) begin
            return CELL_W'(GRID_DIM - 1);
        end else begin
            return c[CELL_W-1:0];
        end
    endfunction

    // distance from the start point to the next boundary along the travel direction
    function automatic logic [ERR_W-1:0] cross_num(input logic signed [DELTA_W-1:0] d,
                                                   input logic [CELL_W-1:0]         cell_idx,
                                                   input logic signed [GRID_W-1:0]  g0);
        logic [CELL_W:0]          bnd;
        logic signed [EDGE_W-1:0] pos;
        logic signed [EDGE_W-1:0] n;
        bnd = d[DELTA_W-1] ? {1'b0, cell_idx} : ({1'b0, cell_idx} + 1'b1);
        pos = $signed(EDGE_W'({bnd, FRAC_W'(0)}));
        if (d[DELTA_W-1]) begin
            n = EDGE_W'(g0) - pos;
        end else begin
            n = pos - EDGE_W'(g0);
        end
        if (d == 0 || n < 0) begin
            return '0;
        end else begin
            return n[ERR_W-1:0];
        end
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_scale <= SCALE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ORIGIN_X:   r_org_x <= $signed(i_cfg_data);
                CFG_ORIGIN_Y:   r_org_y <= $signed(i_cfg_data);
                CFG_CELL_SCALE: r_scale <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // one endpoint coordinate per cycle through the mapping multiplier
    always_comb begin
        unique case (i_cmd.map_sel)
            MAP_SX: begin
                map_pt  = r_seg.start_x;
                map_org = r_org_x;
            end
            MAP_SY: begin
                map_pt  = r_seg.start_y;
                map_org = r_org_y;
            end
            MAP_EX: begin
                map_pt  = r_seg.end_x;
                map_org = r_org_x;
            end
            default: begin
                map_pt  = r_seg.end_y;
                map_org = r_org_y;
            end
        endcase
    end

    assign map_diff = DIFF_W'(map_pt) - DIFF_W'(map_org);
    assign map_prod = map_diff * $signed({1'b0, r_scale});
    assign map_grid = map_prod[MAPP_W-2:FRAC_W];

    // step decision from the registered crossing products
    always_comb begin
        dx_nz     = (r_dx != 0);
        dy_nz     = (r_dy != 0);
        pick_x    = dx_nz && (!dy_nz || (r_prod_x <= r_prod_y));
        pick_y    = !pick_x && dy_nz;
        at_edge_x = r_dx[DELTA_W-1] ? (r_col == '0) : (r_col == CELL_W'(GRID_DIM - 1));
        at_edge_y = r_dy[DELTA_W-1] ? (r_row == '0) : (r_row == CELL_W'(GRID_DIM - 1));
        stop      = 1'b0;
        border    = 1'b0;
        priority if ((!pick_x && !pick_y) || (r_steps <= STEP_W'(1))) begin
            stop = 1'b1;
        end else if (pick_x) begin
            if (r_err_x >= r_adx) begin
                stop = 1'b1;
            end else if (at_edge_x) begin
                stop   = 1'b1;
                border = 1'b1;
            end
        end else begin
            if (r_err_y >= r_ady) begin
                stop = 1'b1;
            end else if (at_edge_y) begin
                stop   = 1'b1;
                border = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_seg <= i_in_data;
        end

        if (i_cmd.map_en) begin
            unique case (i_cmd.map_sel)
                MAP_SX:  r_gsx <= map_grid;
                MAP_SY:  r_gsy <= map_grid;
                MAP_EX:  r_gex <= map_grid;
                default: r_gey <= map_grid;
            endcase
        end

        if (i_cmd.init_en) begin
            r_dx    <= DELTA_W'(r_gex) - DELTA_W'(r_gsx);
            r_dy    <= DELTA_W'(r_gey) - DELTA_W'(r_gsy);
            r_col   <= clamp_cell(r_gsx);
            r_row   <= clamp_cell(r_gsy);
            r_steps <= STEP_W'(MAX_CELLS);
        end

        if (i_cmd.err_en) begin
            r_adx   <= r_dx[DELTA_W-1] ? ERR_W'(-r_dx) : ERR_W'(r_dx);
            r_ady   <= r_dy[DELTA_W-1] ? ERR_W'(-r_dy) : ERR_W'(r_dy);
            r_err_x <= cross_num(r_dx, r_col, r_gsx);
            r_err_y <= cross_num(r_dy, r_row, r_gsy);
        end

        if (i_cmd.mul_en) begin
            r_prod_x <= r_err_x * r_ady;
            r_prod_y <= r_err_y * r_adx;
        end

        if (i_cmd.emit_en) begin
            r_out.cell_col  <= OUT_CELL_W'(r_col);
            r_out.cell_row  <= OUT_CELL_W'(r_row);
            r_out.tag_out   <= r_seg.edge_tag;
            r_out.last_cell <= stop;
            r_out.left_grid <= border;
            if (!stop) begin
                // a taken step never starts from a clamped crossing, so it grows by one cell
                if (pick_x) begin
                    r_col   <= r_dx[DELTA_W-1] ? (r_col - 1'b1) : (r_col + 1'b1);
                    r_err_x <= r_err_x + ERR_W'(CELL_SPAN);
                end else begin
                    r_row   <= r_dy[DELTA_W-1] ? (r_row - 1'b1) : (r_row + 1'b1);
                    r_err_y <= r_err_y + ERR_W'(CELL_SPAN);
                end
                r_steps <= r_steps - 1'b1;
            end
        end
    end

    assign o_sts.stop = stop;
    assign o_out_data = r_out;

endmodule

### design/grid_line_cell_traversal.sv
// top level of the grid line cell traversal block
//
//  channel   direction  handshake               payload
//  in        input      i_in_valid / o_in_stall  i_in_data  (t_seg_in)
//  out       output     o_out_valid / i_out_stall o_out_data (t_cell_out)
//  cfg       input      i_cfg_we                 i_cfg_idx, i_cfg_data
//
// a segment's set-up runs through accept, four mapping multiplies on one
// multiplier, delta and clamp, and crossing numerators; then each cell takes
// a step for the crossing cross-products and a step for the decision and emit.
// a segment yields at most 63 cells.
// a stall on the output side holds the emit cycle; a new request is taken
// as soon as the final cell of the previous one sits in the output register.
// reset is synchronous and clears the sequencer, output valid and config registers.
module grid_line_cell_traversal import glct_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_seg_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_cell_out            o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    glct_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    glct_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_data  (i_in_data),
        .i_cmd      (dp_cmd),
        .o_sts      (dp_sts),
        .o_out_data (o_out_data)
    );

`ifndef SYNTHESIS
    // a border stop is always the final cell
    a_border_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.left_grid || o_out_data.last_cell))
        else $error("left_grid set on a cell that is not the last one");

    // an accepted request closes the input side once it is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input open right after accepting a request");

    // when ready for a new request, only a final cell may still be pending
    a_idle_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && o_out_valid) |-> o_out_data.last_cell)
        else $error("idle while a non-final cell is pending");
`endif

endmodule
